// File: rtl/pbr_pkg.sv
// Package for the page buffer replacement engine: commands, policies, status codes.
// No dependencies.
`default_nettype none
package pbr_pkg;
  localparam int unsigned PAGE_W = 10;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  localparam logic [1:0] POL_LRU     = 2'd0;
  localparam logic [1:0] POL_MRU     = 2'd1;
  localparam logic [1:0] POL_NOCACHE = 2'd2;
  localparam logic [1:0] POL_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [0:0] CFG_POLICY   = 1'd0;
  localparam logic [0:0] CFG_CAPACITY = 1'd1;

  localparam int unsigned MAX_RES = 16;

  typedef struct packed {
    logic [1:0]        status;
    logic              hit;
    logic              fetch_needed;
    logic              direct_access;
    logic              victim_valid;
    logic [PAGE_W-1:0] victim_page;
    logic              writeback_needed;
    logic [PAGE_W-1:0] result_page;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PAGE_W-1:0] page_number;
  } request_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic search;
    logic early;
    logic update;
    logic flush_step;
    logic flush_last;
  } pbr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_flush;
    logic mfound;
    logic dfound;
    logic dmore;
    logic early;
  } pbr_sts_t;
endpackage
`default_nettype wire

// File: rtl/pbr_stream_if.sv
// Valid/ready channel interface carrying one word of type T.
// No package dependency; the payload type T is a parameter.
`default_nettype none
interface pbr_stream_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/pbr_datapath.sv
// Datapath: recency-ordered tag/dirty list, counters, match search, result word.
// Depends on pbr_pkg; driven by pbr_ctrl commands.
`default_nettype none
module pbr_datapath
  import pbr_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int MAX_PAGES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [4:0]        cfg_data,
  input  wire request_t          req,
  input  wire pbr_cmd_t          cmd_in,
  output pbr_sts_t               sts,
  output result_t                res
);
  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(MAX_PAGES + 1);

  logic [PAGE_W-1:0] tag   [SLOTS];
  logic              dirty [SLOTS];
  logic [CW-1:0]     count;
  logic [NW-1:0]     pages;
  logic [1:0]        policy;
  logic [4:0]        capacity;
  request_t          rq;
  logic [PW-1:0]     mpos;
  logic              mfound;
  logic [CW-1:0]     walk;

  logic [CW-1:0] ecap;
  logic          nocache;
  always_comb begin
    if (capacity == 5'd0) ecap = CW'(1);
    else if (32'(capacity) > SLOTS) ecap = CW'(SLOTS);
    else ecap = CW'(capacity);
  end
  assign nocache = policy[1];

  // one comparator per slot, registered match position
  logic [SLOTS-1:0] mvec;
  always_comb begin
    for (int i = 0; i < SLOTS; i++)
      mvec[i] = (tag[i] == rq.page_number) && (CW'(i) < count);
  end

  logic [PW-1:0] mpos_next;
  always_comb begin
    mpos_next = '0;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (mvec[i]) mpos_next = PW'(i);
  end

  // next dirty slot at or after walk
  logic [SLOTS-1:0] dvec;
  always_comb begin
    for (int i = 0; i < SLOTS; i++)
      dvec[i] = dirty[i] && (CW'(i) < count) && (CW'(i) >= walk);
  end

  logic [PW-1:0] dpos;
  logic          dfound;
  always_comb begin
    dpos = '0;
    dfound = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (dvec[i]) begin
        dpos = PW'(i);
        dfound = 1'b1;
      end
  end

  assign sts.is_flush  = (rq.cmd == CMD_FLUSH);
  assign sts.mfound    = mfound;
  assign sts.dfound    = dfound;
  // another dirty slot remains beyond the one reported now
  assign sts.dmore     = |(dvec & (dvec - SLOTS'(1)));
  assign sts.early     = (rq.cmd == CMD_APPEND) ? (32'(pages) >= MAX_PAGES || nocache)
                                                : (32'(rq.page_number) >= 32'(pages)
                                                   || nocache);

  // victim and reorder helpers
  logic [PW-1:0] rm_pos;
  logic          do_rm;
  logic [CW-1:0] n_after;
  logic          new_dirty;
  logic [PAGE_W-1:0] new_tag;
  always_comb begin
    do_rm = 1'b0;
    rm_pos = '0;
    new_dirty = (rq.cmd != CMD_READ);
    new_tag = (rq.cmd == CMD_APPEND) ? PAGE_W'(pages) : rq.page_number;
    if (rq.cmd != CMD_APPEND && mfound) begin
      do_rm = 1'b1;
      rm_pos = mpos;
      new_dirty = dirty[mpos] || (rq.cmd == CMD_WRITE);
    end else if (count >= ecap && count != '0) begin
      do_rm = 1'b1;
      rm_pos = (policy == POL_MRU) ? '0 : PW'(count - CW'(1));
    end
    n_after = do_rm ? count - CW'(1) : count;
    if (n_after >= CW'(SLOTS)) n_after = CW'(SLOTS - 1);
  end

  // result word for the command of this cycle
  result_t res_next;
  logic    bump_pages;
  always_comb begin
    res_next = res;
    bump_pages = 1'b0;
    if (cmd_in.early) begin
      res_next = '0;
      res_next.last = 1'b1;
      if (rq.cmd == CMD_APPEND) begin
        if (32'(pages) >= MAX_PAGES) res_next.status = ST_FULL;
        else begin
          res_next.direct_access = 1'b1;
          res_next.result_page = PAGE_W'(pages);
          bump_pages = 1'b1;
        end
      end else if (32'(rq.page_number) >= 32'(pages)) res_next.status = ST_RANGE;
      else begin
        res_next.direct_access = 1'b1;
        res_next.fetch_needed = (rq.cmd == CMD_READ);
        res_next.result_page = rq.page_number;
      end
    end else if (cmd_in.update) begin
      res_next = '0;
      res_next.last = 1'b1;
      res_next.result_page = new_tag;
      res_next.hit = (rq.cmd != CMD_APPEND) && mfound;
      res_next.fetch_needed = (rq.cmd == CMD_READ) && !mfound;
      if (do_rm && !(rq.cmd != CMD_APPEND && mfound)) begin
        res_next.victim_valid = 1'b1;
        res_next.victim_page = tag[rm_pos];
        res_next.writeback_needed = dirty[rm_pos];
      end
      bump_pages = (rq.cmd == CMD_APPEND);
    end else if (cmd_in.flush_step) begin
      res_next = '0;
      if (dfound) begin
        res_next.victim_valid = 1'b1;
        res_next.victim_page = tag[dpos];
        res_next.writeback_needed = 1'b1;
      end
      res_next.last = cmd_in.flush_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag[i] <= '0;
        dirty[i] <= 1'b0;
      end
      count    <= CW'(1);
      pages    <= NW'(1);
      policy   <= POL_LRU;
      capacity <= 5'd16;
      walk     <= '0;
      mfound   <= 1'b0;
      mpos     <= '0;
      res      <= '0;
    end else begin
      res <= res_next;
      if (bump_pages) pages <= pages + NW'(1);
      if (cfg_we) begin
        if (cfg_idx == CFG_POLICY) policy <= cfg_data[1:0];
        else capacity <= cfg_data;
      end
      if (cmd_in.load) begin
        rq   <= req;
        walk <= '0;
      end
      if (cmd_in.search) begin
        mfound <= |mvec;
        mpos <= mpos_next;
      end
      if (cmd_in.update) begin
        // close the gap at rm_pos and shift the head down by one
        for (int i = 1; i < SLOTS; i++) begin
          if (!do_rm || PW'(i) <= rm_pos) begin
            tag[i] <= tag[i-1];
            dirty[i] <= dirty[i-1];
          end
        end
        tag[0] <= new_tag;
        dirty[0] <= new_dirty;
        count <= n_after + CW'(1);
      end
      if (cmd_in.flush_step && dfound) begin
        dirty[dpos] <= 1'b0;
        walk <= CW'(dpos) + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/pbr_ctrl.sv
// Controller: sequences load, search, early or list update, and flush walk; owns the output handshake.
// Depends on pbr_pkg command and status types.
`default_nettype none
module pbr_ctrl
  import pbr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     out_last,
  input  wire pbr_sts_t sts,
  output pbr_cmd_t      cmd
);
  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_DECIDE, S_FLUSH, S_OUT} state_t;
  state_t   state;
  logic [4:0] nres;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.search = (state == S_SEARCH);
    cmd.early = (state == S_DECIDE) && !sts.is_flush && sts.early;
    cmd.update = (state == S_DECIDE) && !sts.is_flush && !sts.early;
    cmd.flush_step = (state == S_FLUSH);
    cmd.flush_last = (state == S_FLUSH) &&
                     (nres == 5'(MAX_RES - 1) || !sts.dfound || !sts.dmore);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      nres <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_SEARCH;
        S_SEARCH: state <= S_DECIDE;
        S_DECIDE: begin
          nres <= '0;
          if (sts.is_flush) state <= S_FLUSH;
          else begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_FLUSH: begin
          // the word is flagged last when no dirty slot remains after it or the word limit is reached
          out_valid <= 1'b1;
          nres <= nres + 5'd1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= out_last ? S_IDLE : S_FLUSH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/page_buffer_replacement.sv
// Top level of the page buffer replacement engine: controller plus datapath.
// Depends on pbr_pkg, pbr_stream_if, pbr_ctrl, pbr_datapath.
//
//  channel | dir | word
//  req     | in  | cmd, page_number
//  rsp     | out | status .. last
//  cfg     | in  | cfg_we, cfg_idx, cfg_data (policy=0, capacity=1)
//
// Read/write/append: accept, match search, list update or direct result, output.
// Flush: accept, search, decide, then a flush step and output per result word (one word when nothing
// is dirty, at most 16), priority scan over slots.
// Reset (synchronous) restores one resident page 0, all clean, LRU, capacity 16.
// A stalled result holds; no new word is taken until the last one leaves.
`default_nettype none
module page_buffer_replacement
  import pbr_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int MAX_PAGES = 1024
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_we,
  input wire logic       cfg_idx,
  input wire logic [4:0] cfg_data,
  pbr_stream_if.sink     req,
  pbr_stream_if.source   rsp
);
  pbr_cmd_t cmd;
  pbr_sts_t sts;
  result_t  res;

  pbr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_last(res.last), .sts(sts), .cmd(cmd)
  );

  pbr_datapath #(.SLOTS(SLOTS), .MAX_PAGES(MAX_PAGES)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req(req.data), .cmd_in(cmd), .sts(sts), .res(res)
  );

  assign rsp.data = res;

  // never take a word while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("input taken while result pending");
  // a result word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(rsp.data)) else $error("result changed in stall");
endmodule
`default_nettype wire

// File: sim/page_buffer_replacement_test.sv
// Self-checking testbench for the page buffer replacement engine.
// Depends on pbr_pkg, pbr_stream_if and page_buffer_replacement.
`timescale 1ns / 100ps
`default_nettype none
module page_buffer_replacement_test;
  import pbr_pkg::*;

  localparam int SLOTS = 16;
  localparam int MAX_PAGES = 1024;
  localparam int PEND_DEPTH = 256;
  localparam int EXP_DEPTH = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [4:0] cfg_data = '0;

  pbr_stream_if #(.T(request_t)) req (.clk(clk));
  pbr_stream_if #(.T(result_t))  rsp (.clk(clk));

  page_buffer_replacement #(.SLOTS(SLOTS), .MAX_PAGES(MAX_PAGES)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the engine state; position 0 holds the newest page.
  logic [9:0]  tag_mirror [SLOTS];
  logic        dirty_mirror [SLOTS];
  int unsigned resident_mirror;
  int unsigned pages_mirror;
  logic [1:0]  policy_mirror;
  logic [4:0]  capacity_mirror;

  // Ring buffers of pending input words and expected result words.
  request_t pending_words [PEND_DEPTH];
  int       pend_wr = 0;
  int       pend_rd = 0;
  result_t  expected_results [EXP_DEPTH];
  int       exp_wr = 0;
  int       exp_rd = 0;
  int       idle_send_pct = 0;
  int       idle_recv_pct = 0;
  int       mismatches = 0;
  bit       req_taken = 1'b0;

  function automatic result_t blank_result();
    result_t r;
    r = '0;
    return r;
  endfunction

  function automatic void expect_word(result_t r);
    expected_results[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic int unsigned limited_capacity();
    if (capacity_mirror < 1) return 1;
    if (capacity_mirror > SLOTS) return SLOTS;
    return 32'(capacity_mirror);
  endfunction

  function automatic void drop_entry(int unsigned pos);
    int unsigned n;
    n = resident_mirror;
    if (pos >= n) return;
    for (int unsigned i = pos; i + 1 < n; i++) begin
      tag_mirror[i] = tag_mirror[i+1];
      dirty_mirror[i] = dirty_mirror[i+1];
    end
    resident_mirror = n - 1;
  endfunction

  function automatic void push_newest(logic [9:0] tag, logic dirty);
    int unsigned n;
    n = resident_mirror;
    if (n >= SLOTS) n = SLOTS - 1;
    for (int unsigned i = n; i > 0; i--) begin
      tag_mirror[i] = tag_mirror[i-1];
      dirty_mirror[i] = dirty_mirror[i-1];
    end
    tag_mirror[0] = tag;
    dirty_mirror[0] = dirty;
    resident_mirror = n + 1;
  endfunction

  // Install a missing page, evicting per policy; victim fields go into r.
  function automatic void install_page(logic [9:0] tag, logic dirty, inout result_t r);
    int unsigned n;
    int unsigned e;
    n = resident_mirror;
    if (n >= limited_capacity() && n > 0) begin
      e = (policy_mirror == POL_MRU) ? 0 : n - 1;
      r.victim_valid = 1'b1;
      r.victim_page = tag_mirror[e];
      r.writeback_needed = dirty_mirror[e];
      drop_entry(e);
    end
    push_newest(tag, dirty);
  endfunction

  // Work out the result words that one request causes and queue them.
  function automatic void predict_results(request_t w);
    result_t r;
    bit nocache;
    int k;
    bit found;
    logic d;
    nocache = policy_mirror[1];
    r = blank_result();
    k = 0;
    found = 1'b0;
    if (w.cmd == CMD_FLUSH) begin
      for (int unsigned i = 0; i < resident_mirror && k < MAX_RES; i++) begin
        if (dirty_mirror[i]) begin
          dirty_mirror[i] = 1'b0;
          r = blank_result();
          r.victim_valid = 1'b1;
          r.victim_page = tag_mirror[i];
          r.writeback_needed = 1'b1;
          expect_word(r);
          k++;
        end
      end
      if (k == 0) begin
        r = blank_result();
        r.last = 1'b1;
        expect_word(r);
      end else begin
        expected_results[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
      end
      return;
    end
    r.last = 1'b1;
    if (w.cmd == CMD_APPEND) begin
      if (pages_mirror >= MAX_PAGES) begin
        r.status = ST_FULL;
      end else begin
        r.result_page = pages_mirror[9:0];
        pages_mirror++;
        if (nocache) r.direct_access = 1'b1;
        else install_page(r.result_page, 1'b1, r);
      end
      expect_word(r);
      return;
    end
    if (w.page_number >= pages_mirror) begin
      r.status = ST_RANGE;
    end else if (nocache) begin
      r.direct_access = 1'b1;
      r.fetch_needed = (w.cmd == CMD_READ);
      r.result_page = w.page_number;
    end else begin
      r.result_page = w.page_number;
      for (int unsigned i = 0; i < resident_mirror && !found; i++) begin
        if (tag_mirror[i] == w.page_number) begin
          d = dirty_mirror[i] | (w.cmd == CMD_WRITE);
          drop_entry(i);
          push_newest(w.page_number, d);
          r.hit = 1'b1;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.fetch_needed = (w.cmd == CMD_READ);
        install_page(w.page_number, w.cmd == CMD_WRITE, r);
      end
    end
    expect_word(r);
  endfunction

  // Handshake tracking is done at the rising edge; the driver advances on it.
  always @(posedge clk) begin
    req_taken <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) predict_results(req.data);
  end

  // Driver: present words at the falling edge, random idle per idle_send_pct.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.data <= '0;
      rsp.ready <= 1'b0;
    end else begin
      if (req.valid && !req_taken) begin
        // hold the word until accepted
      end else if (pend_wr != pend_rd &&
                   $urandom_range(99) >= idle_send_pct) begin
        req.data <= pending_words[pend_rd % PEND_DEPTH];
        pend_rd++;
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
      rsp.ready <= ($urandom_range(99) >= idle_recv_pct);
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", rsp.data);
      end else begin
        want = expected_results[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (rsp.data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, rsp.data);
        end
      end
    end
  end

  task automatic queue_word(logic [1:0] c, logic [9:0] p);
    request_t w;
    w.cmd = c;
    w.page_number = p;
    pending_words[pend_wr % PEND_DEPTH] = w;
    pend_wr++;
  endtask

  // Wait until every queued word is accepted and every result has come.
  task automatic drain();
    while (pend_wr != pend_rd || req.valid || exp_wr != exp_rd)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) policy_mirror = value[1:0];
    else capacity_mirror = value;
  endtask

  // Mixed commands, mostly valid pages below 40, some random pages that may be out of range.
  task automatic queue_random(int count);
    int c;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(99);
      if (c < 8) queue_word(CMD_FLUSH, 10'($urandom));
      else if (c < 22) queue_word(CMD_APPEND, 10'($urandom));
      else if (c < 30) queue_word(2'($urandom_range(1)), 10'($urandom));
      else queue_word(2'($urandom_range(1)),
                      10'($urandom_range((pages_mirror > 40 ? 40 : pages_mirror) - 1)));
    end
  endtask

  initial begin
    resident_mirror = 1;
    pages_mirror = 1;
    policy_mirror = POL_LRU;
    capacity_mirror = 5'd16;
    for (int i = 0; i < SLOTS; i++) begin
      tag_mirror[i] = '0;
      dirty_mirror[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every command, out of range, empty flush.
    idle_send_pct = 23;
    idle_recv_pct = 71;
    queue_word(CMD_FLUSH, 10'd0);
    queue_word(CMD_READ, 10'd0);
    queue_word(CMD_READ, 10'd1023);
    queue_word(CMD_WRITE, 10'd1);
    for (int i = 0; i < 18; i++) queue_word(CMD_APPEND, 10'h3FF);
    queue_word(CMD_WRITE, 10'd0);
    queue_word(CMD_FLUSH, 10'h3FF);
    drain();

    // Capacity 1 with a read and a write, then MRU at capacity 4 under random traffic.
    write_reg(CFG_CAPACITY, 5'd1);
    queue_word(CMD_READ, 10'd3);
    queue_word(CMD_WRITE, 10'd5);
    drain();
    write_reg(CFG_POLICY, 5'(POL_MRU));
    write_reg(CFG_CAPACITY, 5'd4);
    queue_random(80);
    drain();

    idle_send_pct = 71;
    idle_recv_pct = 23;
    write_reg(CFG_POLICY, 5'(POL_NOCACHE));
    write_reg(CFG_CAPACITY, 5'd0);
    queue_random(60);
    drain();
    write_reg(CFG_POLICY, 5'(POL_UNUSED));
    write_reg(CFG_CAPACITY, 5'd31);
    queue_random(60);
    drain();

    idle_send_pct = 0;
    idle_recv_pct = 0;
    write_reg(CFG_POLICY, 5'(POL_LRU));
    write_reg(CFG_CAPACITY, 5'd16);
    queue_random(120);
    drain();
    write_reg(CFG_CAPACITY, 5'd6);
    queue_random(80);
    drain();
    queue_random(40);
    drain();

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
